// ===== hdl/ohpu_pkg.sv =====
// Package for the odometry heading/position update block.
// Angle constants, CORDIC arctangent table and shared command/status types.
// No dependencies.
`default_nettype none
package ohpu_pkg;

   localparam int COUNT_BITS_DEF   = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX_STEPS = 24;

   localparam logic signed [17:0] ANG_PI      = 18'sd25736;
   localparam logic signed [17:0] ANG_2PI     = 18'sd51472;
   localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
   localparam logic signed [17:0] ANG_3HALF   = 18'sd38604;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [15:0] DPC_RESET = 16'd1344;

   localparam logic CSR_DPC   = 1'b0;
   localparam logic CSR_START = 1'b1;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture input beat, deltas, new heading
      logic prep;       // mean angle, fold, multiply distance
      logic cordic_init;
      logic cordic_step;
      logic round;      // round cos/sin
      logic mul;        // distance times cos/sin
      logic commit;     // accumulate, saturate, update stores
   } ohpu_cmd_type;

   typedef struct packed {
      logic cordic_last;
   } ohpu_sts_type;

endpackage
`default_nettype wire

// ===== hdl/ohpu_datapath.sv =====
// Datapath of the odometry update: deltas, heading wrap, CORDIC, accumulate.
// Depends on ohpu_pkg.
`default_nettype none
module ohpu_datapath #(
   parameter int COUNT_BITS   = ohpu_pkg::COUNT_BITS_DEF,
   parameter int CORDIC_STEPS = ohpu_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ohpu_pkg::ohpu_cmd_type      cmd,
   output      ohpu_pkg::ohpu_sts_type      sts,
   input  wire logic [15:0]                 dpc,
   input  wire logic signed [15:0]          start_heading,
   input  wire logic [31:0]                 left_count,
   input  wire logic [31:0]                 right_count,
   input  wire logic signed [15:0]          measured_heading,
   output      logic signed [31:0]          x_position,
   output      logic signed [31:0]          y_position,
   output      logic signed [15:0]          heading
);
   import ohpu_pkg::*;

   localparam int ITER_BITS = $clog2(CORDIC_STEPS);

   logic [COUNT_BITS-1:0] last_left_ff, last_left_in;
   logic [COUNT_BITS-1:0] last_right_ff, last_right_in;
   logic signed [15:0]    heading_ff, heading_in;
   logic signed [31:0]    x_ff, x_in, y_ff, y_in;
   logic signed [COUNT_BITS:0] dsum_ff, dsum_in;
   logic signed [17:0]    new_a_ff, new_a_in;
   logic signed [17:0]    old_a_ff, old_a_in;
   logic signed [COUNT_BITS+17:0] sumq8_ff, sumq8_in;
   logic                  neg_ff, neg_in;
   logic signed [33:0]    cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   logic signed [17:0]    c15_ff, c15_in, s15_ff, s15_in;
   logic signed [COUNT_BITS+35:0] px_ff, px_in, py_ff, py_in;

   logic [COUNT_BITS-1:0] cl, cr, dl, dr;
   logic signed [18:0]    raw_a, wr_a, hw;
   logic signed [18:0]    avg_a, fold_a;
   logic                  fold_neg;
   logic signed [33:0]    xs, ys, xf, yf;
   logic signed [COUNT_BITS+36:0] ax, ay;

   // Wrap into [0, 2pi) for values in (-2pi, 4pi)
   function automatic logic signed [18:0] wrap(input logic signed [18:0] v);
      logic signed [18:0] r;
      r = v;
      if (r < 0) r = r + 19'(ANG_2PI);
      else if (r >= 19'(ANG_2PI)) r = r - 19'(ANG_2PI);
      return r;
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [COUNT_BITS+36:0] v);
      if (v > (COUNT_BITS+37)'(64'sd2147483647)) return 32'sh7fffffff;
      if (v < -(COUNT_BITS+37)'(64'sd2147483648)) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Load: deltas, new heading (measured +/-pi range is mod 2pi; two wraps cover 16 bits)
   always_comb begin
      cl = left_count[COUNT_BITS-1:0];
      cr = right_count[COUNT_BITS-1:0];
      dl = cl - last_left_ff;
      dr = cr - last_right_ff;
      raw_a = 19'(measured_heading) + 19'(ANG_HALF_PI) - 19'(start_heading);
      if (raw_a < -19'(ANG_2PI)) raw_a = raw_a + 19'(ANG_2PI);
      else if (raw_a >= 19'sd2 * 19'(ANG_2PI)) raw_a = raw_a - 19'(ANG_2PI);
      wr_a = wrap(raw_a);
      hw = wrap(19'(heading_ff));
      avg_a = (19'(old_a_ff) + 19'(new_a_ff)) >>> 1;
      fold_a = avg_a;
      fold_neg = 1'b0;
      if (fold_a >= 19'(ANG_3HALF)) fold_a = fold_a - 19'(ANG_2PI);
      if (fold_a > 19'(ANG_HALF_PI)) begin
         fold_a = fold_a - 19'(ANG_PI);
         fold_neg = 1'b1;
      end
      xs = cx_ff >>> iter_ff;
      ys = cy_ff >>> iter_ff;
      xf = neg_ff ? -cx_ff : cx_ff;
      yf = neg_ff ? -cy_ff : cy_ff;
      ax = (COUNT_BITS+37)'(x_ff) + (COUNT_BITS+37)'(px_ff >>> 16);
      ay = (COUNT_BITS+37)'(y_ff) + (COUNT_BITS+37)'(py_ff >>> 16);
   end

   // Next-state selection
   always_comb begin
      last_left_in = last_left_ff; last_right_in = last_right_ff;
      heading_in = heading_ff; x_in = x_ff; y_in = y_ff;
      dsum_in = dsum_ff; new_a_in = new_a_ff; old_a_in = old_a_ff;
      sumq8_in = sumq8_ff; neg_in = neg_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; iter_in = iter_ff;
      c15_in = c15_ff; s15_in = s15_ff; px_in = px_ff; py_in = py_ff;
      if (cmd.load) begin
         dsum_in = (COUNT_BITS+1)'($signed(dl)) + (COUNT_BITS+1)'($signed(dr));
         last_left_in = cl;
         last_right_in = cr;
         new_a_in = wr_a[17:0];
         old_a_in = hw[17:0];
      end
      if (cmd.prep) begin
         sumq8_in = (COUNT_BITS+18)'(dsum_ff * $signed({1'b0, dpc}));
         neg_in = fold_neg;
         cz_in = 34'(fold_a) <<< 17;
      end
      if (cmd.cordic_init) begin
         cx_in = CORDIC_GAIN_Q30;
         cy_in = '0;
         iter_in = '0;
      end
      if (cmd.cordic_step) begin
         if (cz_ff >= 0) begin
            cx_in = cx_ff - ys; cy_in = cy_ff + xs;
            cz_in = cz_ff - atan_q30(5'(iter_ff));
         end else begin
            cx_in = cx_ff + ys; cy_in = cy_ff - xs;
            cz_in = cz_ff + atan_q30(5'(iter_ff));
         end
         iter_in = iter_ff + 1'b1;
      end
      if (cmd.round) begin
         c15_in = 18'((xf + 34'sd16384) >>> 15);
         s15_in = 18'((yf + 34'sd16384) >>> 15);
      end
      if (cmd.mul) begin
         px_in = (COUNT_BITS+36)'(sumq8_ff * c15_ff);
         py_in = (COUNT_BITS+36)'(sumq8_ff * s15_ff);
      end
      if (cmd.commit) begin
         x_in = sat(ax);
         y_in = sat(ay);
         heading_in = (new_a_ff >= ANG_PI) ? 16'(new_a_ff - ANG_2PI) : new_a_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff <= '0; last_right_ff <= '0;
         heading_ff <= '0; x_ff <= '0; y_ff <= '0;
      end else begin
         last_left_ff <= last_left_in; last_right_ff <= last_right_in;
         heading_ff <= heading_in; x_ff <= x_in; y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      dsum_ff <= dsum_in; new_a_ff <= new_a_in; old_a_ff <= old_a_in;
      sumq8_ff <= sumq8_in; neg_ff <= neg_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; iter_ff <= iter_in;
      c15_ff <= c15_in; s15_ff <= s15_in; px_ff <= px_in; py_ff <= py_in;
   end

   assign sts.cordic_last = (iter_ff == ITER_BITS'(CORDIC_STEPS - 1));
   assign x_position = x_ff;
   assign y_position = y_ff;
   assign heading    = heading_ff;

endmodule
`default_nettype wire

// ===== hdl/ohpu_ctrl.sv =====
// Sequencer of the odometry update: one beat at a time through the datapath.
// Depends on ohpu_pkg.
`default_nettype none
module ohpu_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      ohpu_pkg::ohpu_cmd_type cmd,
   input  wire ohpu_pkg::ohpu_sts_type sts
);
   import ohpu_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_ITER  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Result register frees when the waiting beat is taken
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cmd.cordic_init = 1'b1;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.cordic_step = 1'b1;
            if (sts.cordic_last) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.commit = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/odometry_heading_position_update.sv =====
// Top level of the odometry heading/position update.
// Depends on ohpu_pkg, ohpu_ctrl and ohpu_datapath.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | left_count, right_count, measured_heading
//   rsp     | rsp_valid/rsp_ready  | x_position, y_position, heading
//   csr     | csr_write            | csr_index, csr_data (no read-back)
//
// A beat passes the load, prep, CORDIC iteration, round, multiply and commit states from
// acceptance to result; the CORDIC iterations run on a single shared rotation unit.
// The next beat can be taken in the cycle the result is first offered, so a new beat
// is never taken before the last one has its result.
// A new beat is taken only when no result waits or the waiting one leaves that cycle.
// Synchronous reset clears stores, configuration and control; working registers
// are loaded before use; no clearing pass.
`default_nettype none
module odometry_heading_position_update #(
   parameter int COUNT_BITS   = ohpu_pkg::COUNT_BITS_DEF,
   parameter int CORDIC_STEPS = ohpu_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [31:0]        req_left_count,
   input  wire logic [31:0]        req_right_count,
   input  wire logic signed [15:0] req_measured_heading,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_x_position,
   output      logic signed [31:0] rsp_y_position,
   output      logic signed [15:0] rsp_heading,
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_data
);
   import ohpu_pkg::*;

   ohpu_cmd_type       cmd;
   ohpu_sts_type       sts;
   logic [15:0]        dpc_ff;
   logic signed [15:0] start_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff   <= DPC_RESET;
         start_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DPC:   dpc_ff   <= csr_data;
            CSR_START: start_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ohpu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .sts
   );

   ohpu_datapath #(.COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .dpc(dpc_ff), .start_heading(start_ff),
      .left_count(req_left_count), .right_count(req_right_count),
      .measured_heading(req_measured_heading),
      .x_position(rsp_x_position), .y_position(rsp_y_position),
      .heading(rsp_heading)
   );

`ifndef SYNTHESIS
   // At most one datapath command at a time, cordic_init (issued with prep) apart
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.cordic_step, cmd.round, cmd.mul, cmd.commit}))
      else $error("overlapping datapath commands");
   // A commit raises the result valid next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without result");
   // No new beat accepted while the CORDIC iterates or the multiply runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.cordic_step || cmd.mul) |-> !req_ready)
      else $error("accept during busy");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/odometry_heading_position_update_tb.sv =====
// Testbench for odometry_heading_position_update: directed and random encoder/heading beats,
// checked against an in-bench fixed-point odometry predictor with CORDIC sin/cos.
// Depends on ohpu_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none

// Predicts pose updates and checks result beats in order
class odo_scoreboard;
   logic [15:0]        dist_per_count;
   logic signed [15:0] start_hdg;
   logic [31:0]        prev_left, prev_right;
   logic signed [15:0] hdg_q;
   longint             x_q, y_q;
   logic signed [31:0] exp_x[$], exp_y[$];
   logic signed [15:0] exp_hdg[$];
   int                 errors, checked;

   function void clear();
      dist_per_count = ohpu_pkg::DPC_RESET;
      start_hdg = 0;
      prev_left = 0; prev_right = 0;
      hdg_q = 0; x_q = 0; y_q = 0;
      exp_x.delete(); exp_y.delete(); exp_hdg.delete();
   endfunction

   function int wrap_turn(int v);
      int r;
      r = v % 51472;
      return (r < 0) ? r + 51472 : r;
   endfunction

   function longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rotation-mode CORDIC, angle in [0, 2pi) Q3.13 -> cos/sin Q1.15
   function void rotate(int a, output longint c15, output longint s15);
      longint xr, yr, zr, t;
      bit     flip;
      flip = 0;
      xr = 652032874; yr = 0;
      if (a >= 38604) a -= 51472;
      if (a > 12868) begin
         a -= 25736; flip = 1;
      end
      zr = longint'(a) * 131072;
      for (int i = 0; i < ohpu_pkg::CORDIC_STEPS_DEF; i++) begin
         if (zr >= 0) begin
            t = xr - shr(yr, i); yr = yr + shr(xr, i); xr = t;
            zr -= ohpu_pkg::atan_q30(i[4:0]);
         end else begin
            t = xr + shr(yr, i); yr = yr - shr(xr, i); xr = t;
            zr += ohpu_pkg::atan_q30(i[4:0]);
         end
      end
      if (flip) begin
         xr = -xr; yr = -yr;
      end
      c15 = shr(xr + 16384, 15);
      s15 = shr(yr + 16384, 15);
   endfunction

   function void note_input(logic [31:0] l, logic [31:0] r, logic signed [15:0] m);
      longint dsum, sum_q8, c15, s15;
      int     new_a, old_a, mean_a;
      logic [31:0] dl, dr;
      dl = l - prev_left; dr = r - prev_right;
      dsum = longint'($signed(dl)) + longint'($signed(dr));
      prev_left = l; prev_right = r;
      sum_q8 = dsum * longint'(dist_per_count);
      new_a = wrap_turn(int'(m) + 12868 - int'(start_hdg));
      old_a = wrap_turn(int'(hdg_q));
      mean_a = (old_a + new_a) / 2;
      rotate(mean_a, c15, s15);
      x_q = clamp32(x_q + shr(sum_q8 * c15, 16));
      y_q = clamp32(y_q + shr(sum_q8 * s15, 16));
      hdg_q = 16'(wrap_turn(new_a + 25736) - 25736);
      exp_x.push_back(32'(x_q)); exp_y.push_back(32'(y_q)); exp_hdg.push_back(hdg_q);
   endfunction

   function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [15:0] h);
      checked++;
      if (exp_x.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      if (x !== exp_x[0]) begin
         $error("x_position expected %0d got %0d", exp_x[0], x); errors++;
      end
      if (y !== exp_y[0]) begin
         $error("y_position expected %0d got %0d", exp_y[0], y); errors++;
      end
      if (h !== exp_hdg[0]) begin
         $error("heading expected %0d got %0d", exp_hdg[0], h); errors++;
      end
      void'(exp_x.pop_front()); void'(exp_y.pop_front()); void'(exp_hdg.pop_front());
   endfunction
endclass

module odometry_heading_position_update_tb;
   import ohpu_pkg::*;

   logic               clock = 0, reset = 1;
   logic               req_valid = 0, rsp_ready = 0;
   logic               req_ready, rsp_valid;
   logic [31:0]        req_left_count = 0, req_right_count = 0;
   logic signed [15:0] req_measured_heading = 0;
   logic signed [31:0] rsp_x_position, rsp_y_position;
   logic signed [15:0] rsp_heading;
   logic               csr_write = 0, csr_index = CSR_DPC;
   logic [15:0]        csr_data = 0;

   odo_scoreboard pose = new();
   longint        cycles = 0;
   int            beats_sent = 0;
   bit            hold_off = 0;
   logic [31:0]   enc_left = 0, enc_right = 0;

   odometry_heading_position_update dut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("odometry_heading_position_update: mismatch");
         $finish;
      end
   end

   // result side: a per-beat wait drawn at random once valid shows, plus one long hold-off
   initial begin
      int wait_n;
      wait_n = $urandom_range(0, 4);
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            pose.check_result(rsp_x_position, rsp_y_position, rsp_heading);
            wait_n = $urandom_range(0, 4);
         end
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
            continue;
         end
         if (wait_n > 0) begin
            rsp_ready <= 0;
            if (rsp_valid) wait_n--;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_DPC) pose.dist_per_count = val;
      else pose.start_hdg = val;
      @(posedge clock);
   endtask

   // valid stays up after the accepting edge until the next beat, a gap or a drain
   task automatic send_beat(logic [31:0] l, logic [31:0] r, logic signed [15:0] m,
                            bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_left_count <= l; req_right_count <= r;
      req_measured_heading <= m;
      do @(posedge clock); while (!req_ready);
      pose.note_input(l, r, m);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pose.exp_x.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // wheel motion: small steps mostly, occasional wild jumps
   task automatic random_beat(bit no_gap);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         enc_left  = enc_left + 32'($signed($urandom_range(0, 400)) - 200);
         enc_right = enc_right + 32'($signed($urandom_range(0, 400)) - 200);
      end else begin
         enc_left = $urandom(); enc_right = $urandom();
      end
      send_beat(enc_left, enc_right,
                ($urandom_range(0, 19) == 0) ? 16'($urandom())
                                             : 16'($signed($urandom_range(0, 51472)) - 25736),
                no_gap);
   endtask

   initial begin
      logic [15:0] dpc_set[4];
      logic signed [15:0] hdg_set[4];
      dpc_set = '{16'd1344, 16'd65535, 16'd0, 16'd300};
      hdg_set = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd4000};
      pose.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: heading extremes, backward wheels, count wrap, saturation
      send_beat(0, 0, 0, 0);
      send_beat(100, 100, 16'sd25736, 0);
      send_beat(50, 50, -16'sd25736, 0);
      send_beat(32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'sd12868, 0);
      send_beat(32'h0000_0010, 32'h0000_0010, -16'sd12868, 0);
      send_beat(32'h8000_0010, 32'h0000_0010, 16'sh7FFF, 0);
      send_beat(32'h0000_0010, 32'h8000_0010, 16'sh8000, 0);
      send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd1, 0);
      send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0, 0);
      send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd0, 0);
      drain();
      write_reg(CSR_DPC, 16'hFFFF);
      write_reg(CSR_START, 16'sd25736);
      for (int i = 0; i < 6; i++)
         send_beat(32'h4000_0000 * i, 32'h4000_0000 * i, 16'(i * 9000 - 25736), 0);
      send_beat(32'h8000_0000, 32'h8000_0000, 16'sd0, 0);
      send_beat(0, 0, 16'sd0, 0);
      drain();
      enc_left = 0; enc_right = 0;
      pose.prev_left = 0; pose.prev_right = 0;
      send_beat(0, 0, 0, 0);

      // random phases across register settings
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         write_reg(CSR_DPC, (ph < 4) ? dpc_set[ph] : 16'($urandom()));
         write_reg(CSR_START, (ph < 4) ? hdg_set[ph]
                                       : 16'($signed($urandom_range(0, 51472)) - 25736));
         if (ph == 2) hold_off = 1;
         for (int k = 0; k < 155; k++)
            random_beat((ph == 2) || ($urandom_range(0, 4) == 0));
      end

      drain();
      $display("covered %0d request beats, %0d result beats, 10 register settings",
               beats_sent, pose.checked);
      if (pose.errors == 0 && pose.exp_x.size() == 0)
         $display("odometry_heading_position_update: match");
      else
         $display("odometry_heading_position_update: mismatch");
      $finish;
   end
endmodule

`default_nettype wire
